/* src/reb_pkg.sv */
// Shared types, codes, constants and the quadrature step table of the encoder front end.
package reb_pkg;

    localparam logic [1:0] CMD_ENCODER = 2'd0;
    localparam logic [1:0] CMD_POLL    = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_VLONG      = 2'd2;
    localparam logic [1:0] REG_WINDOW     = 2'd3;

    localparam logic [15:0] DEBOUNCE_RESET   = 16'd30;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd800;
    localparam logic [15:0] VLONG_RESET      = 16'd2000;
    localparam logic [15:0] WINDOW_RESET     = 16'd400;
    localparam logic [15:0] WINDOW_MIN_MS    = 16'd120;

    localparam logic [31:0] SPEED_RESET  = 32'd350;
    localparam logic [31:0] CLICK_MIN_MS = 32'd35;

    localparam int ACCEL_LIMIT = 96;

    localparam logic [5:0] DIR_CW  = 6'h10;
    localparam logic [5:0] DIR_CCW = 6'h20;

    localparam int FLAG_SINGLE = 0;
    localparam int FLAG_DOUBLE = 1;
    localparam int FLAG_TRIPLE = 2;
    localparam int FLAG_LONG   = 3;
    localparam int FLAG_VLONG  = 4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic        pin_a;
        logic        pin_b;
        logic        button_raw;
    } reb_item_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] very_long_press_ms;
        logic [15:0] multi_click_window_ms;
    } reb_cfg_t;

    typedef struct packed {
        logic step_emit;
    } reb_enc_status_t;

    typedef struct packed {
        logic stable_next;
        logic press_abort;
    } reb_btn_status_t;

    function automatic logic [5:0] step_lookup(input logic [2:0] row, input logic [1:0] col);
        logic [5:0] result;
        result = 6'h00;
        case ({row, col})
            5'b000_01: result = 6'd2;
            5'b000_10: result = 6'd4;
            5'b001_00: result = 6'd3;
            5'b001_10: result = 6'd1;
            5'b001_11: result = DIR_CW;
            5'b010_00: result = 6'd3;
            5'b010_01: result = 6'd2;
            5'b011_00: result = 6'd3;
            5'b011_01: result = 6'd2;
            5'b011_10: result = 6'd1;
            5'b100_00: result = 6'd6;
            5'b100_10: result = 6'd4;
            5'b101_00: result = 6'd6;
            5'b101_01: result = 6'd5;
            5'b101_11: result = DIR_CCW;
            5'b110_00: result = 6'd6;
            5'b110_01: result = 6'd5;
            5'b110_10: result = 6'd4;
            default:   result = 6'h00;
        endcase
        return result;
    endfunction

endpackage

/* src/reb_encoder.sv */
// Quadrature step decoder with speed filter, acceleration factor and saturating sum.
module reb_encoder
#(
    parameter int ACCEL_LIMIT = reb_pkg::ACCEL_LIMIT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     proc,
    input  reb_pkg::reb_item_t       item,
    output logic signed [7:0]        accel_sum,
    output reb_pkg::reb_enc_status_t status
);

    localparam logic signed [9:0] LIMIT_POS = 10'(ACCEL_LIMIT);
    localparam logic signed [9:0] LIMIT_NEG = -10'(ACCEL_LIMIT);

    logic [2:0]         quad_state_reg;
    logic [2:0]         quad_state_next;
    logic [31:0]        last_step_time_reg;
    logic [31:0]        speed_filter_reg;
    logic [31:0]        speed_filter_next;
    logic signed [7:0]  accel_sum_reg;
    logic signed [7:0]  accel_sum_next;
    logic [2:0]         row;
    logic [5:0]         lookup;
    logic               is_cw;
    logic               is_ccw;
    logic [31:0]        elapsed;
    logic [31:0]        filter_sum;
    logic [4:0]         factor;
    logic signed [9:0]  sum_wide;
    logic               enc_item;

    assign enc_item = proc && (item.cmd == reb_pkg::CMD_ENCODER);
    assign row      = (quad_state_reg == 3'd7) ? 3'd0 : quad_state_reg;
    assign lookup   = reb_pkg::step_lookup(row, {item.pin_b, item.pin_a});
    assign is_cw    = (lookup & 6'h30) == reb_pkg::DIR_CW;
    assign is_ccw   = (lookup & 6'h30) == reb_pkg::DIR_CCW;
    assign quad_state_next = lookup[2:0];

    assign elapsed           = item.now_ms - last_step_time_reg;
    assign filter_sum        = speed_filter_reg + {speed_filter_reg[30:0], 1'b0} + elapsed;
    assign speed_filter_next = {2'b00, filter_sum[31:2]};

    always_comb
    begin
        if (speed_filter_next < 32'd25)
            factor = 5'd16;
        else if (speed_filter_next < 32'd35)
            factor = 5'd8;
        else if (speed_filter_next < 32'd45)
            factor = 5'd4;
        else if (speed_filter_next < 32'd60)
            factor = 5'd2;
        else
            factor = 5'd1;
    end

    always_comb
    begin
        if (is_cw)
            sum_wide = 10'(accel_sum_reg) + $signed({5'b00000, factor});
        else
            sum_wide = 10'(accel_sum_reg) - $signed({5'b00000, factor});
        if (sum_wide > LIMIT_POS)
            accel_sum_next = LIMIT_POS[7:0];
        else if (sum_wide < LIMIT_NEG)
            accel_sum_next = LIMIT_NEG[7:0];
        else
            accel_sum_next = sum_wide[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_state_reg     <= 3'd0;
            last_step_time_reg <= 32'd0;
            speed_filter_reg   <= reb_pkg::SPEED_RESET;
            accel_sum_reg      <= 8'sd0;
        end
        else if (enc_item)
        begin
            quad_state_reg <= quad_state_next;
            if (is_cw || is_ccw)
            begin
                last_step_time_reg <= item.now_ms;
                speed_filter_reg   <= speed_filter_next;
                accel_sum_reg      <= accel_sum_next;
            end
        end
        else if (proc && (item.cmd == reb_pkg::CMD_READ))
        begin
            accel_sum_reg <= 8'sd0;
        end
    end

    assign accel_sum        = accel_sum_reg;
    assign status.step_emit = enc_item && (is_cw || is_ccw);

endmodule

/* src/reb_button.sv */
// Button debounce, click counting, long press detection and event flags.
module reb_button
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     proc,
    input  reb_pkg::reb_item_t       item,
    input  reb_pkg::reb_cfg_t        cfg,
    input  reb_pkg::reb_enc_status_t enc_status,
    output logic [4:0]               event_flags,
    output reb_pkg::reb_btn_status_t status
);

    logic        rotated_reg;
    logic        rotated_next;
    logic        last_raw_reg;
    logic        stable_reg;
    logic        stable_next;
    logic [31:0] debounce_start_reg;
    logic [31:0] debounce_start_next;
    logic [31:0] press_start_reg;
    logic [31:0] press_start_next;
    logic        long_reg;
    logic        long_next;
    logic        vlong_reg;
    logic        vlong_next;
    logic [1:0]  clicks_reg;
    logic [1:0]  clicks_next;
    logic [31:0] last_release_reg;
    logic [31:0] last_release_next;
    logic [4:0]  flags_reg;
    logic [4:0]  flags_next;
    logic        press_abort;
    logic        poll_item;
    logic [31:0] held;

    assign poll_item = proc && (item.cmd == reb_pkg::CMD_POLL);

    always_comb
    begin
        debounce_start_next = debounce_start_reg;
        stable_next         = stable_reg;
        press_start_next    = press_start_reg;
        long_next           = long_reg;
        vlong_next          = vlong_reg;
        rotated_next        = rotated_reg;
        clicks_next         = clicks_reg;
        last_release_next   = last_release_reg;
        flags_next          = flags_reg;
        press_abort         = 1'b0;
        held                = 32'd0;

        if (item.button_raw != last_raw_reg)
            debounce_start_next = item.now_ms;

        if (((item.now_ms - debounce_start_next) > {16'd0, cfg.debounce_ms})
            && (item.button_raw != stable_reg))
        begin
            stable_next = item.button_raw;
            if (!item.button_raw)
            begin
                press_start_next = item.now_ms;
                long_next        = 1'b0;
                vlong_next       = 1'b0;
                rotated_next     = 1'b0;
                press_abort      = 1'b1;
            end
            else if (!rotated_reg && !long_reg && !vlong_reg
                     && ((item.now_ms - press_start_reg) > reb_pkg::CLICK_MIN_MS))
            begin
                if (clicks_reg != 2'd3)
                    clicks_next = clicks_reg + 2'd1;
                last_release_next = item.now_ms;
            end
        end

        if (!stable_next && !rotated_next)
        begin
            held = item.now_ms - press_start_next;
            if (!long_next && (held >= {16'd0, cfg.long_press_ms}))
            begin
                long_next = 1'b1;
                flags_next[reb_pkg::FLAG_LONG] = 1'b1;
            end
            if (!vlong_next && (held >= {16'd0, cfg.very_long_press_ms}))
            begin
                vlong_next = 1'b1;
                flags_next[reb_pkg::FLAG_VLONG] = 1'b1;
            end
        end

        if (!(!stable_next && rotated_next) && (clicks_next != 2'd0)
            && ((item.now_ms - last_release_next) >= {16'd0, cfg.multi_click_window_ms}))
        begin
            case (clicks_next)
                2'd3:    flags_next[reb_pkg::FLAG_TRIPLE] = 1'b1;
                2'd2:    flags_next[reb_pkg::FLAG_DOUBLE] = 1'b1;
                default: flags_next[reb_pkg::FLAG_SINGLE] = 1'b1;
            endcase
            clicks_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotated_reg        <= 1'b0;
            last_raw_reg       <= 1'b1;
            stable_reg         <= 1'b1;
            debounce_start_reg <= 32'd0;
            press_start_reg    <= 32'd0;
            long_reg           <= 1'b0;
            vlong_reg          <= 1'b0;
            clicks_reg         <= 2'd0;
            last_release_reg   <= 32'd0;
            flags_reg          <= 5'd0;
        end
        else if (poll_item)
        begin
            rotated_reg        <= rotated_next;
            last_raw_reg       <= item.button_raw;
            stable_reg         <= stable_next;
            debounce_start_reg <= debounce_start_next;
            press_start_reg    <= press_start_next;
            long_reg           <= long_next;
            vlong_reg          <= vlong_next;
            clicks_reg         <= clicks_next;
            last_release_reg   <= last_release_next;
            flags_reg          <= flags_next;
        end
        else if (proc && (item.cmd == reb_pkg::CMD_READ))
        begin
            flags_reg <= 5'd0;
        end
        else if (enc_status.step_emit && !item.button_raw)
        begin
            rotated_reg <= 1'b1;
        end
    end

    assign event_flags        = flags_reg;
    assign status.stable_next = poll_item ? stable_next : stable_reg;
    assign status.press_abort = poll_item && press_abort;

endmodule

/* src/rotary_encoder_button_input.sv */
// A beat passes the input register, then the result register.
// Throughput: one beat per cycle while out_stall is low; the input register takes a beat
// while a result waits. Stalls on the result side hold both registers; in_stall rises only
// when both are full. Reset (rst_n, asynchronous, active low) clears all decoder, button and
// event state and loads the configuration registers with their default values.
module rotary_encoder_button_input
#(
    parameter int ACCEL_LIMIT = reb_pkg::ACCEL_LIMIT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [31:0]       now_ms,
    input  logic              pin_a,
    input  logic              pin_b,
    input  logic              button_raw,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [7:0] delta,
    output logic              single_click,
    output logic              double_click,
    output logic              triple_click,
    output logic              long_press,
    output logic              very_long_press,
    output logic              abort,
    output logic              button_held,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    reb_pkg::reb_item_t       item_reg;
    logic                     in_valid_reg;
    reb_pkg::reb_cfg_t        cfg_reg;
    reb_pkg::reb_enc_status_t enc_status;
    reb_pkg::reb_btn_status_t btn_status;
    logic signed [7:0]        accel_sum;
    logic [4:0]               event_flags;
    logic                     abort_flag_reg;
    logic                     proc;
    logic                     in_take;
    logic                     is_read;
    logic                     out_valid_reg;
    logic signed [7:0]        delta_reg;
    logic [4:0]               flags_out_reg;
    logic                     abort_reg;
    logic                     held_reg;

    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign in_take   = in_valid && !in_stall;
    assign proc      = in_valid_reg && !(out_valid_reg && out_stall);
    assign is_read   = item_reg.cmd == reb_pkg::CMD_READ;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd        <= cmd;
            item_reg.now_ms     <= now_ms;
            item_reg.pin_a      <= pin_a;
            item_reg.pin_b      <= pin_b;
            item_reg.button_raw <= button_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms           <= reb_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ms         <= reb_pkg::LONG_PRESS_RESET;
            cfg_reg.very_long_press_ms    <= reb_pkg::VLONG_RESET;
            cfg_reg.multi_click_window_ms <= reb_pkg::WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                reb_pkg::REG_DEBOUNCE:   cfg_reg.debounce_ms        <= cfg_data;
                reb_pkg::REG_LONG_PRESS: cfg_reg.long_press_ms      <= cfg_data;
                reb_pkg::REG_VLONG:      cfg_reg.very_long_press_ms <= cfg_data;
                reb_pkg::REG_WINDOW:
                    cfg_reg.multi_click_window_ms <= (cfg_data < reb_pkg::WINDOW_MIN_MS)
                                                     ? reb_pkg::WINDOW_MIN_MS : cfg_data;
                default: ;
            endcase
        end
    end

    reb_encoder
    #(
        .ACCEL_LIMIT (ACCEL_LIMIT)
    )
    u_encoder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc      (proc),
        .item      (item_reg),
        .accel_sum (accel_sum),
        .status    (enc_status)
    );

    reb_button u_button
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .proc        (proc),
        .item        (item_reg),
        .cfg         (cfg_reg),
        .enc_status  (enc_status),
        .event_flags (event_flags),
        .status      (btn_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abort_flag_reg <= 1'b0;
        end
        else if (proc)
        begin
            if (enc_status.step_emit || btn_status.press_abort)
                abort_flag_reg <= 1'b1;
            else if (item_reg.cmd == reb_pkg::CMD_CLEAR)
                abort_flag_reg <= 1'b0;
            else if (is_read && item_reg.button_raw)
                abort_flag_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            delta_reg     <= is_read ? accel_sum : 8'sd0;
            flags_out_reg <= is_read ? event_flags : 5'd0;
            abort_reg     <= is_read && (!item_reg.button_raw || abort_flag_reg);
            held_reg      <= !btn_status.stable_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign delta           = delta_reg;
    assign single_click    = flags_out_reg[reb_pkg::FLAG_SINGLE];
    assign double_click    = flags_out_reg[reb_pkg::FLAG_DOUBLE];
    assign triple_click    = flags_out_reg[reb_pkg::FLAG_TRIPLE];
    assign very_long_press = flags_out_reg[reb_pkg::FLAG_VLONG];
    assign long_press      = flags_out_reg[reb_pkg::FLAG_LONG]
                             && !flags_out_reg[reb_pkg::FLAG_VLONG];
    assign abort           = abort_reg;
    assign button_held     = held_reg;

`ifndef SYNTH
    a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register could drain");

    a_long_excludes_vlong: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(long_press && very_long_press))
        else $error("long and very long press reported in the same beat");

    a_delta_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (($signed(delta) <= 8'(ACCEL_LIMIT))
                       && ($signed(delta) >= -8'(ACCEL_LIMIT))))
        else $error("encoder sum beyond its saturation limit");

    a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(delta) && $stable(abort)))
        else $error("stalled result changed");
`endif

endmodule

/* tb/tb_rotary_encoder_button_input.sv */
// Self-checking testbench for the rotary encoder and push-button front end.
module tb_rotary_encoder_button_input;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic signed [7:0] delta;
        logic              single_click;
        logic              double_click;
        logic              triple_click;
        logic              long_press;
        logic              very_long_press;
        logic              abort;
        logic              button_held;
    } reb_report_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        cmd;
    logic [31:0]       now_ms;
    logic              pin_a;
    logic              pin_b;
    logic              button_raw;
    logic              out_valid;
    logic              out_stall;
    logic signed [7:0] delta;
    logic              single_click;
    logic              double_click;
    logic              triple_click;
    logic              long_press;
    logic              very_long_press;
    logic              abort;
    logic              button_held;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [15:0]       cfg_data;

    reb_report_t report_q[$];

    int mismatches = 0;
    int beats_sent = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_asked = 0;
    int hold_cycles = 0;

    logic [31:0] now_t;

    logic [31:0] debounce_cfg;
    logic [31:0] long_cfg;
    logic [31:0] vlong_cfg;
    logic [31:0] window_cfg;

    logic [2:0]  quad_pos;
    logic [31:0] last_detent_ms;
    logic [31:0] interval_avg;
    int          accum;
    logic        abort_pending;
    logic        turned_in_press;
    logic        raw_prev;
    logic        btn_stable;
    logic [31:0] bounce_start_ms;
    logic [31:0] press_start_ms;
    logic        long_seen;
    logic        vlong_seen;
    int          click_count;
    logic [31:0] release_ms;
    logic [4:0]  event_bits;

    rotary_encoder_button_input DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .now_ms          (now_ms),
        .pin_a           (pin_a),
        .pin_b           (pin_b),
        .button_raw      (button_raw),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .delta           (delta),
        .single_click    (single_click),
        .double_click    (double_click),
        .triple_click    (triple_click),
        .long_press      (long_press),
        .very_long_press (very_long_press),
        .abort           (abort),
        .button_held     (button_held),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rotary_encoder_button_input regression: fail");
            $finish;
        end
    end

    // Random receiver stalls, with an occasional long hold-off on request.
    initial
    begin : stall_driver
        int hold_left;
        int hold_given;
        hold_left = 0;
        hold_given = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_asked != hold_given)
            begin
                hold_given = hold_asked;
                hold_left = hold_cycles;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic logic [5:0] quad_next(input logic [2:0] pos, input logic [1:0] pins);
        logic [23:0] row;
        case (pos)
            3'd1:    row = {reb_pkg::DIR_CW, 6'd1, 6'd0, 6'd3};
            3'd2:    row = {6'd0, 6'd0, 6'd2, 6'd3};
            3'd3:    row = {6'd0, 6'd1, 6'd2, 6'd3};
            3'd4:    row = {6'd0, 6'd4, 6'd0, 6'd6};
            3'd5:    row = {reb_pkg::DIR_CCW, 6'd0, 6'd5, 6'd6};
            3'd6:    row = {6'd0, 6'd4, 6'd5, 6'd6};
            default: row = {6'd0, 6'd4, 6'd2, 6'd0};
        endcase
        return row[pins * 6 +: 6];
    endfunction

    task automatic reset_front_end();
        debounce_cfg = 32'(reb_pkg::DEBOUNCE_RESET);
        long_cfg = 32'(reb_pkg::LONG_PRESS_RESET);
        vlong_cfg = 32'(reb_pkg::VLONG_RESET);
        window_cfg = 32'(reb_pkg::WINDOW_RESET);
        quad_pos = 3'd0;
        last_detent_ms = 32'd0;
        interval_avg = reb_pkg::SPEED_RESET;
        accum = 0;
        abort_pending = 1'b0;
        turned_in_press = 1'b0;
        raw_prev = 1'b1;
        btn_stable = 1'b1;
        bounce_start_ms = 32'd0;
        press_start_ms = 32'd0;
        long_seen = 1'b0;
        vlong_seen = 1'b0;
        click_count = 0;
        release_ms = 32'd0;
        event_bits = 5'd0;
    endtask

    task automatic advance_front_end(input reb_pkg::reb_item_t it);
        reb_report_t rep;
        logic [5:0]  nxt;
        logic [5:0]  dir;
        logic [31:0] elapsed;
        logic [31:0] held;
        logic        finalize;
        int          step;
        rep = '0;
        case (it.cmd)
            reb_pkg::CMD_ENCODER:
            begin
                nxt = quad_next(quad_pos, {it.pin_b, it.pin_a});
                quad_pos = nxt[2:0];
                dir = nxt & (reb_pkg::DIR_CW | reb_pkg::DIR_CCW);
                if (dir == reb_pkg::DIR_CW || dir == reb_pkg::DIR_CCW)
                begin
                    elapsed = it.now_ms - last_detent_ms;
                    interval_avg = (interval_avg * 32'd3 + elapsed) >> 2;
                    if (interval_avg < 32'd25)
                        step = 16;
                    else if (interval_avg < 32'd35)
                        step = 8;
                    else if (interval_avg < 32'd45)
                        step = 4;
                    else if (interval_avg < 32'd60)
                        step = 2;
                    else
                        step = 1;
                    last_detent_ms = it.now_ms;
                    accum = accum + ((dir == reb_pkg::DIR_CW) ? step : -step);
                    if (accum > reb_pkg::ACCEL_LIMIT)
                        accum = reb_pkg::ACCEL_LIMIT;
                    if (accum < -reb_pkg::ACCEL_LIMIT)
                        accum = -reb_pkg::ACCEL_LIMIT;
                    abort_pending = 1'b1;
                    if (!it.button_raw)
                        turned_in_press = 1'b1;
                end
            end
            reb_pkg::CMD_POLL:
            begin
                if (it.button_raw != raw_prev)
                begin
                    raw_prev = it.button_raw;
                    bounce_start_ms = it.now_ms;
                end
                if (it.now_ms - bounce_start_ms > debounce_cfg && it.button_raw != btn_stable)
                begin
                    btn_stable = it.button_raw;
                    if (!it.button_raw)
                    begin
                        press_start_ms = it.now_ms;
                        long_seen = 1'b0;
                        vlong_seen = 1'b0;
                        turned_in_press = 1'b0;
                        abort_pending = 1'b1;
                    end
                    else if (!turned_in_press && !long_seen && !vlong_seen &&
                             it.now_ms - press_start_ms > reb_pkg::CLICK_MIN_MS)
                    begin
                        if (click_count < 3)
                            click_count++;
                        release_ms = it.now_ms;
                    end
                end
                finalize = 1'b1;
                if (!btn_stable)
                begin
                    if (turned_in_press)
                    begin
                        finalize = 1'b0;
                    end
                    else
                    begin
                        held = it.now_ms - press_start_ms;
                        if (!long_seen && held >= long_cfg)
                        begin
                            long_seen = 1'b1;
                            event_bits[reb_pkg::FLAG_LONG] = 1'b1;
                        end
                        if (!vlong_seen && held >= vlong_cfg)
                        begin
                            vlong_seen = 1'b1;
                            event_bits[reb_pkg::FLAG_VLONG] = 1'b1;
                        end
                    end
                end
                if (finalize && click_count != 0 && it.now_ms - release_ms >= window_cfg)
                begin
                    if (click_count >= 3)
                        event_bits[reb_pkg::FLAG_TRIPLE] = 1'b1;
                    else if (click_count == 2)
                        event_bits[reb_pkg::FLAG_DOUBLE] = 1'b1;
                    else
                        event_bits[reb_pkg::FLAG_SINGLE] = 1'b1;
                    click_count = 0;
                end
            end
            reb_pkg::CMD_READ:
            begin
                rep.delta = accum[7:0];
                accum = 0;
                rep.single_click = event_bits[reb_pkg::FLAG_SINGLE];
                rep.double_click = event_bits[reb_pkg::FLAG_DOUBLE];
                rep.triple_click = event_bits[reb_pkg::FLAG_TRIPLE];
                rep.very_long_press = event_bits[reb_pkg::FLAG_VLONG];
                rep.long_press = event_bits[reb_pkg::FLAG_VLONG] ? 1'b0
                                 : event_bits[reb_pkg::FLAG_LONG];
                event_bits = 5'd0;
                if (!it.button_raw)
                begin
                    rep.abort = 1'b1;
                end
                else
                begin
                    rep.abort = abort_pending;
                    abort_pending = 1'b0;
                end
            end
            default:
            begin
                abort_pending = 1'b0;
            end
        endcase
        rep.button_held = ~btn_stable;
        report_q.push_back(rep);
    endtask

    function automatic string report_text(input reb_report_t r);
        return $sformatf("delta=%0d single=%b double=%b triple=%b long=%b vlong=%b %s",
                         r.delta, r.single_click, r.double_click, r.triple_click,
                         r.long_press, r.very_long_press,
                         $sformatf("abort=%b held=%b", r.abort, r.button_held));
    endfunction

    always @(posedge clk)
    begin : check_beat
        reb_report_t seen;
        reb_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.delta = delta;
            seen.single_click = single_click;
            seen.double_click = double_click;
            seen.triple_click = triple_click;
            seen.long_press = long_press;
            seen.very_long_press = very_long_press;
            seen.abort = abort;
            seen.button_held = button_held;
            if (report_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %s", report_text(seen));
            end
            else
            begin
                want = report_q.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch, expected: %s", report_text(want));
                        $display("mismatch, actual:   %s", report_text(seen));
                    end
                end
            end
        end
    end

    task automatic send_beat(input logic [1:0] c, input logic [31:0] t,
                             input logic a, input logic b, input logic raw);
        reb_pkg::reb_item_t it;
        it.cmd = c;
        it.now_ms = t;
        it.pin_a = a;
        it.pin_b = b;
        it.button_raw = raw;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= it.cmd;
        now_ms <= it.now_ms;
        pin_a <= it.pin_a;
        pin_b <= it.pin_b;
        button_raw <= it.button_raw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_front_end(it);
        beats_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            reb_pkg::REG_DEBOUNCE:   debounce_cfg = 32'(data);
            reb_pkg::REG_LONG_PRESS: long_cfg = 32'(data);
            reb_pkg::REG_VLONG:      vlong_cfg = 32'(data);
            default:
                window_cfg = (data < reb_pkg::WINDOW_MIN_MS) ? 32'(reb_pkg::WINDOW_MIN_MS)
                                                             : 32'(data);
        endcase
    endtask

    task automatic write_all(input logic [15:0] deb, input logic [15:0] lng,
                             input logic [15:0] vlng, input logic [15:0] win);
        write_reg(reb_pkg::REG_DEBOUNCE, deb);
        write_reg(reb_pkg::REG_LONG_PRESS, lng);
        write_reg(reb_pkg::REG_VLONG, vlng);
        write_reg(reb_pkg::REG_WINDOW, win);
    endtask

    task automatic pace(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    task automatic poll(input logic raw);
        send_beat(reb_pkg::CMD_POLL, now_t, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), raw);
    endtask

    task automatic read_events(input logic raw);
        send_beat(reb_pkg::CMD_READ, now_t, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), raw);
        now_t += $urandom_range(0, 3);
    endtask

    function automatic logic [31:0] pick_gap();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1, 2:    return $urandom_range(0, 1000);
            default: return $urandom_range(0, 70);
        endcase
    endfunction

    function automatic logic [31:0] near(input logic [31:0] mark);
        if (mark == 32'd0)
            return $urandom_range(0, 1);
        return mark - 32'd1 + $urandom_range(0, 2);
    endfunction

    function automatic logic [31:0] pick_hold();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 45);
            1:       return 36 + $urandom_range(0, 300);
            2:       return near(long_cfg);
            3:       return near(vlong_cfg);
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    task automatic detent(input bit cw, input logic raw, input logic [31:0] gap);
        now_t += gap;
        if (cw)
        begin
            send_beat(reb_pkg::CMD_ENCODER, now_t, 1'b1, 1'b0, raw);
            send_beat(reb_pkg::CMD_ENCODER, now_t, 1'b0, 1'b0, raw);
            send_beat(reb_pkg::CMD_ENCODER, now_t, 1'b0, 1'b1, raw);
            send_beat(reb_pkg::CMD_ENCODER, now_t, 1'b1, 1'b1, raw);
        end
        else
        begin
            send_beat(reb_pkg::CMD_ENCODER, now_t, 1'b0, 1'b1, raw);
            send_beat(reb_pkg::CMD_ENCODER, now_t, 1'b0, 1'b0, raw);
            send_beat(reb_pkg::CMD_ENCODER, now_t, 1'b1, 1'b0, raw);
            send_beat(reb_pkg::CMD_ENCODER, now_t, 1'b1, 1'b1, raw);
        end
    endtask

    task automatic press_cycle(input logic [31:0] hold, input bit turn);
        logic [31:0] pressed_at;
        if ($urandom_range(0, 3) == 0)
        begin
            poll(1'b0);
            now_t += 1 + $urandom_range(0, 5);
            poll(1'b1);
            now_t += 1 + $urandom_range(0, 5);
        end
        poll(1'b0);
        now_t += debounce_cfg + 1;
        poll(1'b0);
        pressed_at = now_t;
        repeat ($urandom_range(0, 3))
        begin
            now_t += hold >> 2;
            poll(1'b0);
        end
        if (turn)
            detent(1'($urandom_range(0, 1)), 1'b0, $urandom_range(0, 60));
        if (now_t - pressed_at < hold)
            now_t = pressed_at + hold;
        poll(1'b1);
        now_t += debounce_cfg + 1;
        poll(1'b1);
    endtask

    task automatic settle();
        now_t += window_cfg - 1;
        poll(1'b1);
        now_t += 1;
        poll(1'b1);
    endtask

    task automatic noise_beat();
        logic [31:0] t;
        if ($urandom_range(0, 3) == 0)
            now_t = $urandom();
        else
            now_t += $urandom_range(0, 50);
        t = now_t;
        send_beat(2'($urandom_range(0, 3)), t, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed();
        send_beat(reb_pkg::CMD_READ, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
        send_beat(reb_pkg::CMD_ENCODER, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
        send_beat(reb_pkg::CMD_ENCODER, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
        send_beat(reb_pkg::CMD_ENCODER, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
        send_beat(reb_pkg::CMD_ENCODER, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_beat(reb_pkg::CMD_ENCODER, 32'h0000_0005, 1'b0, 1'b1, 1'b1);
        send_beat(reb_pkg::CMD_ENCODER, 32'h0000_0005, 1'b0, 1'b0, 1'b1);
        send_beat(reb_pkg::CMD_ENCODER, 32'h0000_0005, 1'b1, 1'b0, 1'b1);
        send_beat(reb_pkg::CMD_ENCODER, 32'h0000_0005, 1'b1, 1'b1, 1'b1);
        // An illegal jump straight to the rest position from the start state emits nothing.
        send_beat(reb_pkg::CMD_ENCODER, 32'h0000_0005, 1'b1, 1'b1, 1'b1);
        send_beat(reb_pkg::CMD_READ, 32'h0000_0006, 1'b1, 1'b1, 1'b0);
        send_beat(reb_pkg::CMD_READ, 32'h0000_0007, 1'b0, 1'b1, 1'b1);
        send_beat(reb_pkg::CMD_CLEAR, 32'h0000_0008, 1'b1, 1'b0, 1'b1);
        // Held for exactly the click threshold: no click.
        send_beat(reb_pkg::CMD_POLL, 32'd100, 1'b0, 1'b0, 1'b0);
        send_beat(reb_pkg::CMD_POLL, 32'd131, 1'b0, 1'b0, 1'b0);
        send_beat(reb_pkg::CMD_POLL, 32'd135, 1'b0, 1'b0, 1'b1);
        send_beat(reb_pkg::CMD_POLL, 32'd166, 1'b0, 1'b0, 1'b1);
        // One millisecond longer: a single click once the window has passed.
        send_beat(reb_pkg::CMD_POLL, 32'd200, 1'b0, 1'b0, 1'b0);
        send_beat(reb_pkg::CMD_POLL, 32'd231, 1'b0, 1'b0, 1'b0);
        send_beat(reb_pkg::CMD_POLL, 32'd236, 1'b0, 1'b0, 1'b1);
        send_beat(reb_pkg::CMD_POLL, 32'd267, 1'b0, 1'b0, 1'b1);
        send_beat(reb_pkg::CMD_POLL, 32'd697, 1'b0, 1'b0, 1'b1);
        send_beat(reb_pkg::CMD_POLL, 32'd698, 1'b0, 1'b0, 1'b1);
        send_beat(reb_pkg::CMD_READ, 32'd700, 1'b0, 1'b0, 1'b1);
        now_t = 32'd1000;
    endtask

    task automatic test_click_counting(input int n);
        int goal;
        goal = beats_sent + n;
        while (beats_sent < goal)
        begin
            repeat ($urandom_range(1, 4))
                press_cycle(30 + $urandom_range(0, 90), 1'b0);
            settle();
            read_events($urandom_range(0, 3) != 0);
        end
    endtask

    task automatic test_rotation_speed(input int n);
        int goal;
        bit cw;
        logic [31:0] gap_top;
        goal = beats_sent + n;
        while (beats_sent < goal)
        begin
            cw = 1'($urandom_range(0, 1));
            gap_top = ($urandom_range(0, 3) == 0) ? 32'd8 : 32'd70;
            repeat ($urandom_range(1, 12))
                detent(cw, $urandom_range(0, 7) != 0, $urandom_range(0, gap_top));
            if ($urandom_range(0, 9) == 0)
                noise_beat();
            if ($urandom_range(0, 1) == 0)
                read_events($urandom_range(0, 5) != 0);
        end
    endtask

    task automatic test_press_durations(input int n);
        int goal;
        goal = beats_sent + n;
        while (beats_sent < goal)
        begin
            press_cycle(pick_hold(), $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0)
                settle();
            read_events($urandom_range(0, 4) != 0);
        end
    endtask

    task automatic test_random_mix(input int n);
        int goal;
        int pick;
        goal = beats_sent + n;
        while (beats_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                press_cycle(pick_hold(), $urandom_range(0, 4) == 0);
            end
            else if (pick < 40)
            begin
                repeat ($urandom_range(1, 3))
                    press_cycle(36 + $urandom_range(0, 80), 1'b0);
                settle();
            end
            else if (pick < 58)
            begin
                repeat ($urandom_range(1, 5))
                    detent(1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0, pick_gap());
            end
            else if (pick < 72)
            begin
                noise_beat();
            end
            else if (pick < 80)
            begin
                settle();
            end
            else if (pick < 95)
            begin
                read_events($urandom_range(0, 3) != 0);
            end
            else
            begin
                send_beat(reb_pkg::CMD_CLEAR, now_t, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_register_extremes();
        write_all(16'd0, 16'd0, 16'd0, 16'd0);
        test_random_mix(60);
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_random_mix(60);
        write_all(16'd30, 16'd2000, 16'd800, 16'd119);
        test_random_mix(40);
        write_reg(reb_pkg::REG_WINDOW, reb_pkg::WINDOW_MIN_MS);
        test_click_counting(40);
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        hold_asked++;
        repeat (12)
            detent(1'($urandom_range(0, 1)), 1'b1, $urandom_range(0, 70));
        read_events(1'b1);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= reb_pkg::CMD_POLL;
        now_ms <= 32'd0;
        pin_a <= 1'b1;
        pin_b <= 1'b1;
        button_raw <= 1'b1;
        cfg_valid <= 1'b0;
        cfg_index <= reb_pkg::REG_DEBOUNCE;
        cfg_data <= 16'd0;
        now_t = 32'd0;
        reset_front_end();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pace(0, 0);
        test_directed();
        test_click_counting(150);

        pace(88, 0);
        test_rotation_speed(150);

        pace(0, 88);
        test_register_extremes();

        pace(13, 13);
        write_all(16'($urandom_range(0, 60)), 16'($urandom_range(200, 1500)),
                  16'($urandom_range(600, 4000)), 16'($urandom_range(120, 600)));
        test_press_durations(150);

        pace(0, 0);
        test_backpressure();

        write_all(reb_pkg::DEBOUNCE_RESET, reb_pkg::LONG_PRESS_RESET,
                  reb_pkg::VLONG_RESET, reb_pkg::WINDOW_RESET);
        pace(13, 13);
        test_random_mix(150);
        pace(0, 0);
        test_random_mix(100);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("rotary_encoder_button_input regression: pass");
        else
            $display("rotary_encoder_button_input regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/reb_pkg.sv
src/reb_encoder.sv
src/reb_button.sv
src/rotary_encoder_button_input.sv
tb/tb_rotary_encoder_button_input.sv
